// ===== hw/rtl/tit_pkg.sv =====
// Shared types and codes for the trusted identity table.
package tit_pkg;

  localparam int unsigned IDX_W = 8;

  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_REMOVE   = 2'd1;
  localparam logic [1:0] OP_EVALUATE = 2'd2;

  typedef struct packed {
    logic [31:0] pid;
    logic [63:0] ctime;
    logic [63:0] key;
    logic [31:0] flags;
    logic [63:0] now;
  } item_t;

  // scan accumulator handed from cell to cell
  typedef struct packed {
    logic             same_hit;
    logic [IDX_W-1:0] same_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
    logic             best_have;
    logic [IDX_W-1:0] best_idx;
    logic [63:0]      best_time;
    logic             match_hit;
    logic [IDX_W-1:0] match_idx;
    logic             stale;
  } acc_t;

  // write-back command broadcast to all cells
  typedef struct packed {
    logic             write;
    logic             clr_same;
    logic             purge;
    logic             refresh;
    logic [IDX_W-1:0] idx;
  } cmd_t;

endpackage

// ===== hw/rtl/tit_cell.sv =====
// One table entry plus its stage of the scan chain.
module tit_cell #(
  parameter int unsigned ME = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tit_pkg::item_t item_i,
  input  tit_pkg::cmd_t  cmd_i,
  input  logic          tok_i,
  input  tit_pkg::acc_t  acc_i,
  output logic          tok_o,
  output tit_pkg::acc_t  acc_o
);
  import tit_pkg::*;

  logic        active_q;
  logic [31:0] pid_q;
  logic [63:0] ctime_q, key_q, ver_q;
  logic [31:0] flags_q;
  logic        same, full;
  logic        tok_q;
  acc_t        acc_q, acc_d;

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(ME);

  assign same = active_q && (pid_q == item_i.pid);
  assign full = same && (ctime_q == item_i.ctime) && (key_q == item_i.key);

  always_comb begin
    acc_d = acc_i;
    if (same && !acc_i.same_hit) begin
      acc_d.same_hit = 1'b1;
      acc_d.same_idx = MyIdx;
    end
    if (!active_q && !acc_i.free_hit) begin
      acc_d.free_hit = 1'b1;
      acc_d.free_idx = MyIdx;
    end
    if (active_q && (!acc_i.best_have || ver_q < acc_i.best_time)) begin
      acc_d.best_have = 1'b1;
      acc_d.best_idx  = MyIdx;
      acc_d.best_time = ver_q;
    end
    if (full && !acc_i.match_hit) begin
      acc_d.match_hit = 1'b1;
      acc_d.match_idx = MyIdx;
    end
    if (same && !full && !acc_i.match_hit) acc_d.stale = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pid_q    <= '0;
      ctime_q  <= '0;
      key_q    <= '0;
      flags_q  <= '0;
      ver_q    <= '0;
      tok_q    <= 1'b0;
      acc_q    <= '0;
    end else begin
      tok_q <= tok_i;
      acc_q <= acc_d;
      if (cmd_i.write && cmd_i.idx == MyIdx) begin
        active_q <= 1'b1;
        pid_q    <= item_i.pid;
        ctime_q  <= item_i.ctime;
        key_q    <= item_i.key;
        flags_q  <= item_i.flags;
        ver_q    <= item_i.now;
      end else if ((cmd_i.clr_same && same) || (cmd_i.purge && same && !full)) begin
        active_q <= 1'b0;
        pid_q    <= '0;
        ctime_q  <= '0;
        key_q    <= '0;
        flags_q  <= '0;
        ver_q    <= '0;
      end else if (cmd_i.refresh && cmd_i.idx == MyIdx) begin
        ver_q <= item_i.now;
      end
    end
  end

  assign tok_o = tok_q;
  assign acc_o = acc_q;

endmodule

// ===== hw/rtl/trusted_identity_table.sv =====
// Top level of the trusted identity table: control, scan chain and result register.
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      tuser op, tdata identity and time
//  m_axis   out  m_axis_tvalid/tready      tdata granted, purged, slot, hit count
//
// After acceptance the start flag is registered, then the scan token walks the row of
// cells one entry a cycle; as it leaves the last cell the result and the write-back
// command are registered. A new word is taken only once the result has been taken.
// Reset clears every entry and the hit counter at once. A stalled result holds.
module trusted_identity_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: process_id[31:0], create_time[95:32], path_present[96],
  //        path_key[160:97], trust_flags[192:161], current_time[256:193], zero pad
  input  logic [263:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: granted[0], stale_purged[1], slot_used[5:2], hit_total[69:6], zero pad
  output logic [71:0]  m_axis_tdata
);
  import tit_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WB   = 2'd2;

  logic [1:0]  state_q, state_d;
  item_t       item_q;
  logic [1:0]  op_q;
  logic        present_q;
  logic        start_q;
  cmd_t        cmd_q, cmd_d;
  logic [63:0] hits_q, hits_d;
  logic        out_valid_q;
  logic        granted_q, granted_d, purged_q, purged_d;
  logic [3:0]  slot_q, slot_d;
  logic        accept, ident_ok, tok_end;
  acc_t        acc_end;

  logic [ENTRIES:0] tok_w;
  acc_t             acc_w [ENTRIES+1];

  assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tok_w[0] = start_q;
  assign acc_w[0] = '0;

  // row of entry cells, scan token moves one cell per cycle
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tit_cell #(.ME(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (item_q),
      .cmd_i  (cmd_q),
      .tok_i  (tok_w[g]),
      .acc_i  (acc_w[g]),
      .tok_o  (tok_w[g+1]),
      .acc_o  (acc_w[g+1])
    );
  end

  assign tok_end  = tok_w[ENTRIES];
  assign acc_end  = acc_w[ENTRIES];
  assign ident_ok = (item_q.pid != '0) && (item_q.ctime != '0) && present_q;

  // decide the write-back once the token leaves the last cell
  always_comb begin
    cmd_d     = '0;
    hits_d    = hits_q;
    granted_d = 1'b0;
    purged_d  = 1'b0;
    slot_d    = '0;
    state_d   = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_SCAN;
      ST_SCAN: begin
        if (tok_end) begin
          state_d = ST_WB;
          case (op_q)
            OP_REGISTER: begin
              if (ident_ok) begin
                cmd_d.write = 1'b1;
                cmd_d.idx   = acc_end.same_hit ? acc_end.same_idx :
                              acc_end.free_hit ? acc_end.free_idx : acc_end.best_idx;
                granted_d   = 1'b1;
                slot_d      = cmd_d.idx[3:0];
              end
            end
            OP_REMOVE: cmd_d.clr_same = (item_q.pid != '0);
            OP_EVALUATE: begin
              if (ident_ok) begin
                cmd_d.purge   = acc_end.stale;
                cmd_d.refresh = acc_end.match_hit;
                cmd_d.idx     = acc_end.match_idx;
                purged_d      = acc_end.stale;
                granted_d     = acc_end.match_hit;
                if (acc_end.match_hit) begin
                  slot_d = acc_end.match_idx[3:0];
                  hits_d = hits_q + 64'd1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_WB:   state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      cmd_q       <= '0;
      hits_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept;
      cmd_q   <= cmd_d;
      hits_q  <= hits_d;
      if (state_q == ST_SCAN && tok_end) out_valid_q <= 1'b1;
      else if (m_axis_tready)            out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= s_axis_tuser;
      item_q.pid   <= s_axis_tdata[31:0];
      item_q.ctime <= s_axis_tdata[95:32];
      present_q    <= s_axis_tdata[96];
      item_q.key   <= s_axis_tdata[160:97];
      item_q.flags <= s_axis_tdata[192:161];
      item_q.now   <= s_axis_tdata[256:193];
    end
    if (state_q == ST_SCAN && tok_end) begin
      granted_q <= granted_d;
      purged_q  <= purged_d;
      slot_q    <= slot_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, hits_q, slot_q, purged_q, granted_q};

  a_wb_after_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && tok_end) |=> (state_q == ST_WB))
    else $error("write-back did not follow scan end");
  a_cmd_only_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_q.write || cmd_q.clr_same || cmd_q.purge || cmd_q.refresh) |-> (state_q == ST_WB))
    else $error("command outside write-back");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("ready while busy");
  a_hits_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hits_q != $past(hits_q)) |-> $past(state_q == ST_SCAN && tok_end))
    else $error("hit count moved outside scan end");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the trusted identity table: random and directed words checked against a predictor.
`timescale 1ns / 1ps

class table_scoreboard;
  localparam int NENT = 16;
  bit          act[NENT];
  bit [31:0]   pid[NENT];
  bit [63:0]   ctm[NENT];
  bit [63:0]   key[NENT];
  bit [31:0]   flg[NENT];
  bit [63:0]   ver[NENT];
  bit [63:0]   hits;
  bit [71:0]   pending[$];
  int          errors;

  function void clear_slot(int i);
    act[i] = 0; pid[i] = 0; ctm[i] = 0; key[i] = 0; flg[i] = 0; ver[i] = 0;
  endfunction

  function void wipe();
    for (int i = 0; i < NENT; i++) clear_slot(i);
    hits = 0;
    errors = 0;
  endfunction

  function bit same(int i, bit [31:0] p, bit [63:0] c, bit [63:0] k);
    return act[i] && pid[i] == p && ctm[i] == c && key[i] == k;
  endfunction

  // apply one accepted word and queue the result it must give
  function void note_word(bit [1:0] op, bit [263:0] d);
    bit [31:0] p;
    bit [63:0] c, k, now;
    bit [31:0] f;
    bit        pres, ok, grant, purged, allow, stale, found;
    bit [3:0]  slot;
    int        s, best;
    p = d[31:0]; c = d[95:32]; pres = d[96]; k = d[160:97];
    f = d[192:161]; now = d[256:193];
    ok = p != 0 && c != 0 && pres;
    grant = 0; purged = 0; slot = 0; allow = 0; stale = 0;
    if (op == tit_pkg::OP_REGISTER && ok) begin
      s = -1;
      for (int i = 0; i < NENT; i++) if (s < 0 && act[i] && pid[i] == p) s = i;
      if (s < 0) begin
        found = 0; best = 0;
        for (int i = 0; i < NENT; i++) begin
          if (!found && !act[i]) begin
            s = i; found = 1;
          end
          if (!found && ver[i] < ver[best]) best = i;
        end
        if (!found) s = best;
      end
      clear_slot(s);
      act[s] = 1; pid[s] = p; ctm[s] = c; key[s] = k; flg[s] = f; ver[s] = now;
      grant = 1; slot = s[3:0];
    end else if (op == tit_pkg::OP_REMOVE && p != 0) begin
      for (int i = 0; i < NENT; i++) if (act[i] && pid[i] == p) clear_slot(i);
    end else if (op == tit_pkg::OP_EVALUATE && ok) begin
      found = 0;
      for (int i = 0; i < NENT; i++)
        if (!found && act[i] && pid[i] == p) begin
          if (same(i, p, c, k)) begin
            allow = 1; found = 1;
          end else stale = 1;
        end
      if (stale)
        for (int i = 0; i < NENT; i++)
          if (act[i] && pid[i] == p && !same(i, p, c, k)) begin
            clear_slot(i); purged = 1;
          end
      if (allow) begin
        found = 0;
        for (int i = 0; i < NENT; i++)
          if (!found && same(i, p, c, k)) begin
            ver[i] = now; slot = i[3:0]; found = 1;
          end
        if (found) begin
          hits = hits + 1; grant = 1;
        end
      end
    end
    pending.push_back({2'b0, hits, slot, purged, grant});
  endfunction

  task check_word(bit [71:0] got);
    bit [71:0] exp;
    if (pending.size() == 0) begin
      report("result with nothing expected", got, 0);
      return;
    end
    exp = pending.pop_front();
    if (got[0] != exp[0]) report("granted", got, exp);
    if (got[1] != exp[1]) report("stale_purged", got, exp);
    if (got[5:2] != exp[5:2]) report("slot_used", got, exp);
    if (got[69:6] != exp[69:6]) report("hit_total", got, exp);
  endtask

  task report(string what, bit [71:0] got, bit [71:0] exp);
    $display("mismatch %s: got %h exp %h", what, got, exp);
    errors++;
  endtask
endclass

module tb_top;
  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [263:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [71:0]  m_axis_tdata;

  table_scoreboard sb;
  int  idle_cycles = 0;
  bit  calm = 0;       // long stretch with no idling
  bit [31:0] pid_pool[8];

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  trusted_identity_table i_dut (.*);

  function automatic bit gap();
    return !calm && $urandom_range(99) < 37;
  endfunction

  // result side: random stall, check on each accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
      m_axis_tready <= !gap();
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bit [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // valid drops only in idle cycles, so each edge sees one assignment
  task automatic send_word(bit [1:0] op, bit [31:0] p, bit [63:0] c, bit pres,
                           bit [63:0] k, bit [31:0] f, bit [63:0] now);
    while (gap()) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'b0, now, f, k, pres, c, p};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, {7'b0, now, f, k, pres, c, p});
  endtask

  // ids, times and keys drawn from small pools so that hits and purges occur
  task automatic send_random();
    bit [1:0]  op;
    bit [31:0] p;
    bit [63:0] c, k;
    op = $urandom_range(99) < 3 ? 2'd3 : 2'($urandom_range(2));
    p = $urandom_range(9) == 0 ? $urandom : pid_pool[$urandom_range(7)];
    c = $urandom_range(9) == 0 ? rnd64() : 64'($urandom_range(2));
    k = $urandom_range(9) == 0 ? rnd64() : 64'($urandom_range(1));
    if ($urandom_range(19) == 0) p = 0;
    send_word(op, p, c, $urandom_range(15) != 0, k, $urandom,
              $urandom_range(3) == 0 ? rnd64() : 64'($urandom_range(20)));
  endtask

  initial begin
    sb = new();
    sb.wipe();
    for (int i = 0; i < 8; i++) pid_pool[i] = i == 7 ? 32'hFFFF_FFFF : i + 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: invalid identities, field extremes, every operation
    send_word(tit_pkg::OP_REGISTER, 0, 1, 1, 0, 0, 0);
    send_word(tit_pkg::OP_REGISTER, 5, 0, 1, 0, 0, 0);
    send_word(tit_pkg::OP_REGISTER, 5, 1, 0, 0, 0, 0);
    send_word(tit_pkg::OP_EVALUATE, 0, 1, 1, 0, 0, 0);
    send_word(tit_pkg::OP_REMOVE, 0, 0, 0, 0, 0, 0);
    send_word(tit_pkg::OP_REGISTER, '1, '1, 1, '1, '1, '1);
    send_word(tit_pkg::OP_EVALUATE, '1, '1, 1, '1, 0, 5);
    send_word(tit_pkg::OP_EVALUATE, '1, '1, 1, 0, 0, 5);   // stale, no match
    send_word(2'd3, '1, '1, 1, '1, '1, '1);                // unused op
    // fill the table, then force oldest-time replacement with ties
    for (int i = 0; i < 17; i++)
      send_word(tit_pkg::OP_REGISTER, 100 + i, 7, 1, 3, i, 64'(i < 4 ? 9 : 10 + i));
    send_word(tit_pkg::OP_REMOVE, 101, 0, 0, 0, 0, 0);
    send_word(tit_pkg::OP_EVALUATE, 102, 7, 1, 3, 0, 1);
    // random: clean stretch in the middle
    for (int n = 0; n < 1550; n++) begin
      calm = n >= 600 && n < 800;
      send_random();
    end
    s_axis_tvalid <= 0;
    calm = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/tit_pkg.sv
hw/rtl/tit_cell.sv
hw/rtl/trusted_identity_table.sv
sim/tb_top.sv
